FILE: rtl/core/sgfc_pkg.sv
// sgfc_pkg: shared types and constants of the scan gap fill and clamp core
// stored sample layout, sample kinds, operation codes, register indexes
// no dependencies
package sgfc_pkg;

    localparam int IDX_W   = 10;
    localparam int RANGE_W = 16;
    localparam int KIND_W  = 2;
    localparam int ANGLE_W = 16;
    localparam int REG_IDX_W = 2;

    // sample kinds as stored
    localparam logic [KIND_W-1:0] KIND_FIN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NAN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INF = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ALT = 2'd3;   // handled as infinite

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_RANGE_MIN   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_MAX   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_START = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [RANGE_W-1:0] rng;
    } sample_t;

endpackage

FILE: rtl/core/scan_gap_fill_and_clamp_core.sv
// scan_gap_fill_and_clamp_core: top level of the scan gap fill and clamp core
// loads samples, repairs the scan in place, reads repaired points with their angle
// uses sgfc_pkg, sgfc_store, sgfc_repair
//
//   channel   | dir | beat contents
//   ----------+-----+---------------------------------------------------------
//   s_ stream | in  | load sample or read request, tlast on a load starts the repair pass
//   m_ stream | out | one repaired point per read request
//   cfg write | in  | lower and upper range limit, start angle, angle step
//
// a load writes the store directly; a read goes through the store read, then the output register
// a last load starts the repair pass: a search for the first valid sample, a priming of
// the read-ahead, then one write-back per sample of the scan
// s_tready stays low during the pass, while a read is in flight and while a
// finished point waits on m_tready; reset clears control state, not the store
module scan_gap_fill_and_clamp_core #(
    parameter int MAX_POINTS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [9:0] point_index, [25:10] range_mm, rest zero
    input  logic [2:0]  s_tuser,   // [0] operation, [2:1] sample_kind
    input  logic        s_tlast,   // last_sample
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] angle, [31:16] range_out
    output logic        m_tuser,   // point_valid
    // configuration writes
    input  logic        cfg_we,
    input  logic [sgfc_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int LWC  = $clog2(MAX_POINTS + 1);
    localparam int LW   = (LWC > sgfc_pkg::IDX_W + 1) ? LWC : sgfc_pkg::IDX_W + 1;
    localparam int PW   = sgfc_pkg::ANGLE_W + sgfc_pkg::IDX_W;

    // input beat fields
    logic                          in_op;
    logic [sgfc_pkg::IDX_W-1:0]    in_index;
    logic [sgfc_pkg::RANGE_W-1:0]  in_range;
    logic [sgfc_pkg::KIND_W-1:0]   in_kind;
    logic [LW-1:0]                 idx_ext;
    logic                          idx_in_store;
    logic                          s_acc;
    logic                          host_we;
    logic                          host_rd;
    logic                          pass_start;
    sgfc_pkg::sample_t             host_wdata;

    // configuration
    logic [sgfc_pkg::RANGE_W-1:0]  lim_lo_reg;
    logic [sgfc_pkg::RANGE_W-1:0]  lim_hi_reg;
    logic [sgfc_pkg::ANGLE_W-1:0]  angle_start_reg;
    logic [sgfc_pkg::ANGLE_W-1:0]  angle_step_reg;

    // scan length and read path
    logic [LW-1:0]                 scan_len_reg;
    logic                          rd_pend_reg;
    logic [sgfc_pkg::ANGLE_W-1:0]  rd_angle_reg;
    logic                          rd_inscan_reg;
    logic [PW-1:0]                 angle_prod;
    logic [sgfc_pkg::ANGLE_W-1:0]  angle_next;

    // output register
    logic                          out_valid_reg;
    logic [sgfc_pkg::ANGLE_W-1:0]  out_angle_reg;
    logic [sgfc_pkg::RANGE_W-1:0]  out_range_reg;
    logic                          out_pvalid_reg;

    // store ports and repair engine
    logic                          eng_busy;
    logic                          eng_we;
    logic [AW-1:0]                 eng_waddr;
    sgfc_pkg::sample_t             eng_wdata;
    logic [AW-1:0]                 eng_raddr;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    sgfc_pkg::sample_t             mem_wdata;
    logic [AW-1:0]                 mem_raddr;
    sgfc_pkg::sample_t             mem_rdata;

    assign in_op    = s_tuser[0];
    assign in_kind  = s_tuser[2:1];
    assign in_index = s_tdata[sgfc_pkg::IDX_W-1:0];
    assign in_range = s_tdata[sgfc_pkg::IDX_W +: sgfc_pkg::RANGE_W];

    assign idx_ext      = LW'(in_index);
    assign idx_in_store = (idx_ext < LW'(MAX_POINTS));

    // no new beat during the pass, behind a pending read, or onto a stalled result
    assign s_tready = !eng_busy && !rd_pend_reg && (!out_valid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;

    // loads past the store are dropped, last mark included
    assign host_we    = s_acc && (in_op == sgfc_pkg::OP_LOAD) && idx_in_store;
    assign host_rd    = s_acc && (in_op == sgfc_pkg::OP_READ);
    assign pass_start = host_we && s_tlast;

    // kind three is kept as infinite
    always_comb begin
        host_wdata.rng  = in_range;
        host_wdata.kind = (in_kind == sgfc_pkg::KIND_ALT) ? sgfc_pkg::KIND_INF : in_kind;
    end

    // wrapping binary angle of the requested point
    assign angle_prod = PW'(angle_step_reg) * PW'(in_index);
    assign angle_next = angle_start_reg + angle_prod[sgfc_pkg::ANGLE_W-1:0];

    // repair engine owns the store while busy
    always_comb begin
        if (eng_busy) begin
            mem_we    = eng_we;
            mem_waddr = eng_waddr;
            mem_wdata = eng_wdata;
            mem_raddr = eng_raddr;
        end else begin
            mem_we    = host_we;
            mem_waddr = AW'(idx_ext);
            mem_wdata = host_wdata;
            mem_raddr = AW'(idx_ext);
        end
    end

    sgfc_store #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sgfc_repair #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW),
        .LW         (LW)
    ) u_repair (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (pass_start),
        .len       (scan_len_reg),
        .clamp_lo  (lim_lo_reg),
        .clamp_hi  (lim_hi_reg),
        .busy      (eng_busy),
        .mem_we    (eng_we),
        .mem_waddr (eng_waddr),
        .mem_wdata (eng_wdata),
        .mem_raddr (eng_raddr),
        .mem_rdata (mem_rdata)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_lo_reg      <= '0;
            lim_hi_reg      <= '1;
            angle_start_reg <= '0;
            angle_step_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sgfc_pkg::REG_RANGE_MIN:   lim_lo_reg      <= cfg_wdata;
                sgfc_pkg::REG_RANGE_MAX:   lim_hi_reg      <= cfg_wdata;
                sgfc_pkg::REG_ANGLE_START: angle_start_reg <= cfg_wdata;
                sgfc_pkg::REG_ANGLE_STEP:  angle_step_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // scan length, read pending flag and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_len_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pass_start) begin
                scan_len_reg <= idx_ext + LW'(1);
            end
            rd_pend_reg <= host_rd;
            if (rd_pend_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // read payload: angle and scan bound captured on accept, store data in the following cycle
    always_ff @(posedge aclk) begin
        if (host_rd) begin
            rd_angle_reg  <= angle_next;
            rd_inscan_reg <= (idx_ext < scan_len_reg);
        end
        if (rd_pend_reg) begin
            out_angle_reg <= rd_angle_reg;
            if (rd_inscan_reg && mem_rdata.kind != sgfc_pkg::KIND_NAN) begin
                out_range_reg  <= mem_rdata.rng;
                out_pvalid_reg <= 1'b1;
            end else begin
                out_range_reg  <= '0;
                out_pvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_range_reg, out_angle_reg};
    assign m_tuser  = out_pvalid_reg;

endmodule

FILE: rtl/core/sgfc_store.sv
// sgfc_store: sample store, one write port and one read port
// read data registered; uses sgfc_pkg
module sgfc_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  sgfc_pkg::sample_t   wdata,
    input  logic [AW-1:0]       raddr,
    output sgfc_pkg::sample_t   rdata
);

    sgfc_pkg::sample_t store_mem [DEPTH];
    sgfc_pkg::sample_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
        rdata_reg <= store_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/sgfc_repair.sv
// sgfc_repair: repair pass sequencer over the sample store
// finds the first valid sample, then walks the scan once writing back repaired beats
// uses sgfc_pkg; drives the store ports while busy
module sgfc_repair #(
    parameter int MAX_POINTS = 1024,
    parameter int AW = $clog2(MAX_POINTS),
    parameter int LW = 11
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [LW-1:0]                 len,
    input  logic [sgfc_pkg::RANGE_W-1:0]  clamp_lo,
    input  logic [sgfc_pkg::RANGE_W-1:0]  clamp_hi,
    output logic                          busy,
    output logic                          mem_we,
    output logic [AW-1:0]                 mem_waddr,
    output sgfc_pkg::sample_t             mem_wdata,
    output logic [AW-1:0]                 mem_raddr,
    input  sgfc_pkg::sample_t             mem_rdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FIND = 3'd1;
    localparam logic [2:0] ST_PR0  = 3'd2;
    localparam logic [2:0] ST_PR1  = 3'd3;
    localparam logic [2:0] ST_RUN  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [LW-1:0]     find_cnt_reg, find_cnt_next;
    logic              chk_ok_reg, chk_ok_next;
    logic [LW-1:0]     pos_reg, pos_next;
    sgfc_pkg::sample_t cur_reg, cur_next;
    sgfc_pkg::sample_t prev_reg, prev_next;
    sgfc_pkg::sample_t first_reg, first_next;
    sgfc_pkg::sample_t pick;
    sgfc_pkg::sample_t fixed;
    logic              last_pos;

    // infinite becomes the upper limit, finite outside the limits too
    function automatic sgfc_pkg::sample_t clamp_sample(
        input sgfc_pkg::sample_t s,
        input logic [sgfc_pkg::RANGE_W-1:0] lo,
        input logic [sgfc_pkg::RANGE_W-1:0] hi
    );
        sgfc_pkg::sample_t r;
        r = s;
        if (s.kind == sgfc_pkg::KIND_INF || s.kind == sgfc_pkg::KIND_ALT) begin
            r.kind = sgfc_pkg::KIND_FIN;
            r.rng  = hi;
        end else if (s.kind == sgfc_pkg::KIND_FIN) begin
            if (s.rng < lo || s.rng > hi) begin
                r.rng = hi;
            end
        end
        return r;
    endfunction

    assign last_pos = (pos_reg == len - LW'(1));

    // gap fill choice for the sample under the walk
    always_comb begin
        pick = cur_reg;
        if (cur_reg.kind == sgfc_pkg::KIND_NAN) begin
            priority if (pos_reg == '0) begin
                pick = first_reg;
            end else if (!last_pos && mem_rdata.kind != sgfc_pkg::KIND_NAN) begin
                pick = mem_rdata;
            end else if (prev_reg.kind != sgfc_pkg::KIND_NAN) begin
                pick = prev_reg;
            end else begin
                pick = cur_reg;
            end
        end
        fixed = clamp_sample(pick, clamp_lo, clamp_hi);
    end

    always_comb begin
        state_next    = state_reg;
        find_cnt_next = find_cnt_reg;
        chk_ok_next   = chk_ok_reg;
        pos_next      = pos_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        first_next    = first_reg;
        mem_raddr     = '0;
        mem_we        = 1'b0;
        mem_waddr     = AW'(pos_reg);
        mem_wdata     = fixed;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next    = ST_FIND;
                    find_cnt_next = '0;
                    chk_ok_next   = 1'b0;
                end
            end
            ST_FIND: begin
                // read data belongs to index find_cnt_reg - 1
                mem_raddr     = AW'(find_cnt_reg);
                find_cnt_next = find_cnt_reg + LW'(1);
                chk_ok_next   = 1'b1;
                if (chk_ok_reg &&
                    (mem_rdata.kind != sgfc_pkg::KIND_NAN || find_cnt_reg == len)) begin
                    first_next = mem_rdata;
                    state_next = ST_PR0;
                end
            end
            ST_PR0: begin
                mem_raddr  = '0;
                state_next = ST_PR1;
            end
            ST_PR1: begin
                mem_raddr  = AW'(LW'(1));
                cur_next   = mem_rdata;
                pos_next   = '0;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                // read two ahead, write back the current one
                mem_raddr = AW'(pos_reg + LW'(2));
                mem_we    = 1'b1;
                cur_next  = mem_rdata;
                prev_next = fixed;
                pos_next  = pos_reg + LW'(1);
                if (last_pos) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            chk_ok_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            chk_ok_reg <= chk_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        find_cnt_reg <= find_cnt_next;
        pos_reg      <= pos_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        first_reg    <= first_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: test/testbench.sv
// testbench for scan_gap_fill_and_clamp_core: loads scans, lets the core repair them,
// reads points back and checks them against a scan repair tracker held in a small class
// depends on sgfc_pkg and scan_gap_fill_and_clamp_core
module testbench;
    import sgfc_pkg::*;

    localparam int MAX_POINTS = 1024;
    // worst repair pass: search, prime, write-back over a full scan, plus margin
    localparam int PASS_DRAIN = 3 * MAX_POINTS + 64;
    localparam int LONG_HOLD  = 400;
    localparam int RUN_LIMIT  = 10_000_000;
    localparam int PHASES     = 8;
    localparam int PHASE_BEATS = 70;
    localparam int BIG_SCAN   = 200;

    typedef struct {
        logic [15:0] angle;
        logic [15:0] range_mm;
        logic        valid;
    } point_t;

    // tracks stored samples, scan length and registers; predicts every read
    class scan_repair_board;
        logic [15:0]  lim_min = 16'h0000;
        logic [15:0]  lim_max = 16'hFFFF;
        logic [15:0]  ang_start = 16'h0000;
        logic [15:0]  ang_step = 16'h0000;
        sample_t      store [MAX_POINTS];
        int unsigned  scan_len = 0;
        point_t       pending_points [$];
        int           mismatches = 0;
        int           strays = 0;
        int           loads = 0;
        int           reads = 0;
        int           passes = 0;
        int           blind_reads = 0;

        function void set_reg(input logic [REG_IDX_W-1:0] which, input logic [15:0] val);
            case (which)
                REG_RANGE_MIN:   lim_min = val;
                REG_RANGE_MAX:   lim_max = val;
                REG_ANGLE_START: ang_start = val;
                REG_ANGLE_STEP:  ang_step = val;
                default: ;
            endcase
        endfunction

        // infinite becomes the upper limit, finite outside the limits too
        function void clamp_entry(input int i);
            if (store[i].kind == KIND_INF) begin
                store[i].kind = KIND_FIN;
                store[i].rng  = lim_max;
            end else if (store[i].kind == KIND_FIN &&
                         (store[i].rng < lim_min || store[i].rng > lim_max)) begin
                store[i].rng = lim_max;
            end
        endfunction

        function void repair_scan();
            for (int i = 0; i < scan_len; i++) begin
                if (store[i].kind == KIND_NAN) begin
                    if (i == 0) begin
                        for (int j = 1; j < scan_len; j++) begin
                            if (store[j].kind != KIND_NAN) begin
                                store[0] = store[j];
                                break;
                            end
                        end
                    end else if (i + 1 < scan_len && store[i+1].kind != KIND_NAN) begin
                        store[i] = store[i+1];
                    end else if (store[i-1].kind != KIND_NAN) begin
                        store[i] = store[i-1];
                    end
                end
                clamp_entry(i);
            end
        endfunction

        function void note_beat(input logic op, input logic [9:0] idx, input logic [15:0] rng,
                                input logic [1:0] kind, input logic last);
            point_t p;
            if (op == OP_LOAD) begin
                store[idx].kind = (kind == KIND_ALT) ? KIND_INF : kind;
                store[idx].rng  = rng;
                loads++;
                if (last) begin
                    scan_len = idx + 1;
                    repair_scan();
                    passes++;
                end
            end else begin
                p.angle    = ang_start + ang_step * {6'd0, idx};
                p.valid    = (idx < scan_len) && (store[idx].kind != KIND_NAN);
                p.range_mm = p.valid ? store[idx].rng : 16'h0000;
                pending_points = {pending_points, p};
                reads++;
            end
        endfunction

        function void check_point(input logic [15:0] angle, input logic [15:0] range_mm,
                                  input logic valid);
            point_t want;
            if (pending_points.size() == 0) begin
                strays++;
                if (strays + mismatches <= 10)
                    $display("unexpected point: angle %h range %0d valid %b",
                             angle, range_mm, valid);
                return;
            end
            want = pending_points.pop_front();
            if (!want.valid)
                blind_reads++;
            if (angle !== want.angle || range_mm !== want.range_mm || valid !== want.valid) begin
                mismatches++;
                if (strays + mismatches <= 10)
                    $display("point mismatch: angle %h/%h range %0d/%0d valid %b/%b (exp/got)",
                             want.angle, angle, want.range_mm, range_mm, want.valid, valid);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_wdata;

    scan_repair_board board;

    // stimulus bookkeeping: which entries hold something, current scan length
    bit written [MAX_POINTS];
    int scan_len_tb = 0;
    int beats_sent = 0;
    int settings_done = 0;

    // idle mix, changed per phase by the main process
    int tx_idle_pct = 32;
    int rx_idle_pct = 53;

    // long receiver hold-off requests, served by the receiver process
    int holds_asked = 0;
    int holds_done = 0;

    scan_gap_fill_and_clamp_core #(
        .MAX_POINTS(MAX_POINTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [9:0] point_index, [25:10] range_mm, rest zero
        .s_tuser  (s_tuser),    // [0] operation, [2:1] sample_kind
        .s_tlast  (s_tlast),    // last_sample
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [15:0] angle, [31:16] range_out
        .m_tuser  (m_tuser),    // point_valid
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // monitor: both handshakes sampled at the edge where they complete
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_beat(s_tuser[0], s_tdata[9:0], s_tdata[25:10], s_tuser[2:1], s_tlast);
            if (m_tvalid && m_tready)
                board.check_point(m_tdata[15:0], m_tdata[31:16], m_tuser);
        end
    end

    // receiver: random back-pressure, or a long hold-off when one is asked for
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_done < holds_asked) begin
                holds_done++;
                repeat (LONG_HOLD) begin
                    m_tready <= 1'b0;
                    @(posedge aclk);
                end
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog
    initial begin
        #(RUN_LIMIT);
        $display("timeout: run stalled, %0d points still expected",
                 board.pending_points.size());
        $display("FAIL scan_gap_fill_and_clamp_core");
        $finish;
    end

    // one beat on the input channel; called right after a rising edge,
    // returns right after the edge that accepted it
    task automatic send_beat(input logic op, input logic [9:0] idx, input logic [15:0] rng,
                             input logic [1:0] kind, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, rng, idx};
        s_tuser  <= {kind, op};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic load_sample(input int idx, input logic [15:0] rng, input logic [1:0] kind,
                               input logic last);
        send_beat(OP_LOAD, idx[9:0], rng, kind, last);
        written[idx] = 1'b1;
        if (last)
            scan_len_tb = idx + 1;
    endtask

    // reads carry random junk in the fields the core ignores
    task automatic read_point(input int idx);
        send_beat(OP_READ, idx[9:0], 16'($urandom_range(16'hFFFF)), 2'($urandom_range(3)),
                  1'($urandom_range(1)));
    endtask

    // register writes happen back to back, write enable dropped once at the end
    task automatic put_reg(input logic [REG_IDX_W-1:0] which, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= val;
        board.set_reg(which, val);
        @(posedge aclk);
    endtask

    task automatic set_limits_and_angles(input logic [15:0] mn, input logic [15:0] mx,
                                         input logic [15:0] start, input logic [15:0] step);
        put_reg(REG_RANGE_MIN, mn);
        put_reg(REG_RANGE_MAX, mx);
        put_reg(REG_ANGLE_START, start);
        put_reg(REG_ANGLE_STEP, step);
        cfg_we <= 1'b0;
        settings_done++;
    endtask

    // wait for every point, then let a possible repair pass finish
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending_points.size() != 0)
            @(posedge aclk);
        repeat (PASS_DRAIN) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_range();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return board.lim_min - 16'd1;
            3: return board.lim_min;
            4: return board.lim_max;
            5: return board.lim_max + 16'd1;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic logic [1:0] pick_kind(input int nan_pct);
        if ($urandom_range(99) < nan_pct)
            return KIND_NAN;
        case ($urandom_range(9))
            0: return KIND_INF;
            1: return KIND_ALT;
            default: return KIND_FIN;
        endcase
    endfunction

    // share of NaN samples in one scan, all-NaN scans included
    function automatic int nan_profile();
        case ($urandom_range(5))
            0: return 0;
            1, 2: return 20;
            3: return 40;
            4: return 70;
            default: return 100;
        endcase
    endfunction

    function automatic int written_prefix();
        int n;
        n = 0;
        while (n < MAX_POINTS && written[n])
            n++;
        return n;
    endfunction

    // mostly inside the scan, sometimes a stored entry just past its end;
    // never an entry that was not loaded
    function automatic int pick_read_idx();
        int idx;
        if (scan_len_tb > 0 && $urandom_range(9) < 8)
            return $urandom_range(scan_len_tb - 1);
        idx = scan_len_tb + $urandom_range(3);
        if (idx < MAX_POINTS && written[idx])
            return idx;
        repeat (8) begin
            idx = $urandom_range(MAX_POINTS - 1);
            if (written[idx])
                return idx;
        end
        return 0;
    endfunction

    // well-formed scan: loads 0 .. n-1, last mark on the final one, occasional reads between loads, then reads
    task automatic run_scan(input int n, input int nan_pct);
        int nreads;
        for (int i = 0; i < n; i++) begin
            load_sample(i, pick_range(), pick_kind(nan_pct), i == n - 1);
            if ($urandom_range(99) < 3)
                read_point(pick_read_idx());
        end
        nreads = $urandom_range(1, (n < 20) ? n / 2 + 2 : 12);
        repeat (nreads) read_point(pick_read_idx());
    endtask

    task automatic random_phase(input bit with_big_scan, input bit with_hold);
        int start_count;
        int choice;
        int n;
        int prefix;
        start_count = beats_sent;
        if (with_big_scan) begin
            // long scan, then its last and first points
            run_scan(BIG_SCAN, 20);
            read_point(BIG_SCAN - 1);
            read_point(0);
        end
        if (with_hold) begin
            // receiver stops for a long stretch while reads keep coming
            run_scan(16, 20);
            holds_asked++;
            repeat (40) read_point(pick_read_idx());
        end
        while (beats_sent - start_count < PHASE_BEATS) begin
            choice = $urandom_range(99);
            if (choice < 65) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(25, 160) : $urandom_range(1, 24);
                run_scan(n, nan_profile());
            end else if (choice < 75) begin
                // broken scan: loads without the last mark
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    load_sample(i, pick_range(), pick_kind(30), 1'b0);
            end else if (choice < 85) begin
                // stray overwrites anywhere in the store
                repeat ($urandom_range(1, 4))
                    load_sample($urandom_range(MAX_POINTS - 1), pick_range(), pick_kind(30), 1'b0);
            end else if (choice < 93) begin
                // new last mark over whatever the store holds now
                prefix = written_prefix();
                n = $urandom_range((prefix < MAX_POINTS) ? prefix : MAX_POINTS - 1);
                load_sample(n, pick_range(), pick_kind(30), 1'b1);
                repeat ($urandom_range(1, 3)) read_point(pick_read_idx());
            end else begin
                repeat ($urandom_range(1, 6)) read_point(pick_read_idx());
            end
        end
    endtask

    initial begin
        int failed;
        board = new;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        s_tlast   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_RANGE_MIN;
        cfg_wdata <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset register values
        // read before any pass: no scan yet, point invalid
        load_sample(7, 16'h0000, KIND_FIN, 1'b0);
        read_point(7);
        // leading NaN run, right-neighbour fill, kind three, trailing NaN run
        load_sample(0, 16'h1111, KIND_NAN, 1'b0);
        load_sample(1, 16'h0000, KIND_NAN, 1'b0);
        load_sample(2, 16'hFFFF, KIND_FIN, 1'b0);
        load_sample(3, 16'h0000, KIND_ALT, 1'b0);
        load_sample(4, 16'd500, KIND_NAN, 1'b0);
        load_sample(5, 16'd42, KIND_NAN, 1'b1);
        read_point(0);
        read_point(1);
        read_point(3);
        read_point(4);
        read_point(5);
        read_point(7);      // past the end of the scan
        // whole scan invalid
        load_sample(0, 16'd9, KIND_NAN, 1'b0);
        load_sample(1, 16'd9, KIND_NAN, 1'b1);
        read_point(0);
        read_point(1);
        // overwrite inside the scan without a new pass
        load_sample(1, 16'h0000, KIND_INF, 1'b0);
        read_point(1);
        load_sample(0, 16'hFFFF, KIND_NAN, 1'b0);
        read_point(0);

        // random part: register settings change between phases only
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            if (phase < 3) begin
                tx_idle_pct = 32;
                rx_idle_pct = 53;
            end else if (phase < 6) begin
                tx_idle_pct = 53;
                rx_idle_pct = 32;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (phase)
                0: set_limits_and_angles(16'd200, 16'd8000, 16'h1234, 16'd37);
                1: set_limits_and_angles(16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
                2: set_limits_and_angles(16'd60000, 16'd10, 16'h7FFF, 16'h8000);   // inverted
                3: set_limits_and_angles(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                4: set_limits_and_angles(16'h0000, 16'hFFFF, 16'h0000, 16'd64);
                5: set_limits_and_angles(16'd1234, 16'd1234, 16'($urandom_range(16'hFFFF)),
                                         16'($urandom_range(16'hFFFF)));
                default: set_limits_and_angles(16'($urandom_range(2000)),
                                               16'($urandom_range(2000, 16'hFFFF)),
                                               16'($urandom_range(16'hFFFF)),
                                               16'($urandom_range(16'hFFFF)));
            endcase
            random_phase(phase == 4, phase == 6);
        end
        drain();

        failed = board.mismatches + board.strays + board.pending_points.size();
        if (board.pending_points.size() != 0)
            $display("%0d expected points never arrived", board.pending_points.size());
        $display("covered %0d loads, %0d reads (%0d invalid points), %0d repair passes",
                 board.loads, board.reads, board.blind_reads, board.passes);
        $display("%0d register settings, %0d long receiver holds, %0d failures",
                 settings_done, holds_done, failed);
        if (failed == 0) begin
            $display("PASS scan_gap_fill_and_clamp_core");
        end else begin
            $display("FAIL scan_gap_fill_and_clamp_core");
        end
        $finish;
    end

endmodule
